### rtl/paddle_stepper_ramp_top_assert.svh
// assertion macros for the paddle stepper ramp block
`ifndef PADDLE_STEPPER_RAMP_TOP_ASSERT_SVH
`define PADDLE_STEPPER_RAMP_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PSR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("paddle stepper ramp check failed");

// consequent must hold in the cycle after the antecedent
`define PSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("paddle stepper ramp check failed");

`endif

### rtl/psr_pkg.sv
// shared constants and types for the paddle stepper ramp block
package psr_pkg;

	// largest number of speed levels on each side of stop
	localparam int MAX_LEVELS = 16;

	// fixed field widths
	localparam int BTN_W  = 4;
	localparam int STEP_W = 2;
	localparam int POS_W  = 32;
	localparam int CFG_W  = 16;
	localparam int SL_W   = 5;
	localparam int SIGN_W = 2;
	localparam int CIDX_W = 3;
	localparam int CNT_W  = 18;

	// widths that follow from the level count
	localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
	localparam int IDX_W  = $clog2(2 * MAX_LEVELS + 1);
	localparam int PROD_W = IDX_W + 1 + CFG_W + 1;
	localparam int NUM_W  = $clog2(MAX_LEVELS * 65536);
	localparam int DIV_CYC = (NUM_W + 1) / 2;
	localparam int DIVN_W = 2 * DIV_CYC;
	localparam int DCNT_W = $clog2(DIV_CYC + 1);
	localparam int RES_W  = DIVN_W + 3;

	// register reset values
	localparam logic [SL_W-1:0]   RST_SPEED_LEVELS = SL_W'(8);
	localparam logic [SL_W-1:0]   RST_MAX_RANGE    = SL_W'(8);
	localparam logic [CFG_W-1:0]  RST_MIN_STEPS    = CFG_W'(1);
	localparam logic [CFG_W-1:0]  RST_MAX_STEPS    = CFG_W'(64);
	localparam logic [CFG_W-1:0]  RST_MIN_DELAY    = CFG_W'(1);
	localparam logic [CFG_W-1:0]  RST_MAX_DELAY    = CFG_W'(100);
	localparam logic [SIGN_W-1:0] RST_START_SIGN   = SIGN_W'(1);

	// configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_SPEED_LEVELS = 3'd0,
		REG_MAX_RANGE    = 3'd1,
		REG_MIN_STEPS    = 3'd2,
		REG_MAX_STEPS    = 3'd3,
		REG_MIN_DELAY    = 3'd4,
		REG_MAX_DELAY    = 3'd5,
		REG_START_SIGN   = 3'd6
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_START  = 7'b0000010,
		S_EVAL   = 7'b0000100,
		S_MUL    = 7'b0001000,
		S_DIV    = 7'b0010000,
		S_WB     = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	// per axis state
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [CNT_W-1:0] skip;
		logic [CNT_W-1:0] ramp;
	} axis_t;

endpackage

### rtl/paddle_stepper_ramp_top.sv
// paddle stepper ramp top level: sequencer, axis state and shared divider
//
// Usage: one input transfer per paddle tick carries the four active-low
// buttons. Each tick yields exactly one result transfer with the x and y
// step pulses (-1, 0, +1), the wrapped positions and a session end flag.
// Both data channels use valid/stall; a transfer happens when valid is high
// and stall is low. The config channel uses valid/ready and is always ready;
// write it only while no tick is in flight.
// Sequence: a tick passes the start state and the finish state, and a running
// tick evaluates each axis in between; the next tick can transfer in the cycle
// in which the previous result is shown. A tick that loads no delay or hold
// value skips the multiply and divide unit. Each per-level delay or ramp length
// passes through the shared multiply and divide unit (a multiply step, radix-4
// restoring divide steps, a writeback); an axis needs none, one or two of them.
// in_stall stays high from the transfer until the result is loaded into the
// output register, so only one tick is worked on at a time.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds its final cycle until the register is free.
// Reset: the configuration and control registers return to their defaults, both axes sit at centre
// with cleared counters, positions are zero and no session is active.
`include "paddle_stepper_ramp_top_assert.svh"

module paddle_stepper_ramp_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// tick input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [psr_pkg::BTN_W-1:0]           buttons,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [psr_pkg::STEP_W-1:0]   x_step,
	output logic signed [psr_pkg::STEP_W-1:0]   y_step,
	output logic signed [psr_pkg::POS_W-1:0]    x_position,
	output logic signed [psr_pkg::POS_W-1:0]    y_position,
	output logic                                session_done,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [psr_pkg::CIDX_W-1:0]          cfg_index,
	input  logic [psr_pkg::CFG_W-1:0]           cfg_data
);
	import psr_pkg::*;

	// configuration registers
	logic [SL_W-1:0]   speed_levels_q;
	logic [SL_W-1:0]   max_range_q;
	logic [CFG_W-1:0]  min_steps_q;
	logic [CFG_W-1:0]  max_steps_q;
	logic [CFG_W-1:0]  min_delay_q;
	logic [CFG_W-1:0]  max_delay_q;
	logic [SIGN_W-1:0] start_sign_q;

	// control and axis state
	state_t              state_q;
	logic                axis_q;
	logic                kind_q;
	logic                session_q;
	logic                done_q;
	axis_t               x_ax_q;
	axis_t               y_ax_q;
	logic [POS_W-1:0]    x_pos_q;
	logic [POS_W-1:0]    y_pos_q;
	logic signed [STEP_W-1:0] x_step_q;
	logic signed [STEP_W-1:0] y_step_q;
	logic [BTN_W-1:0]    btn_q;
	logic                out_valid_q;

	// divider registers
	logic [DIVN_W-1:0]   num_q;
	logic [LVL_W-1:0]    rem_q;
	logic [DCNT_W-1:0]   dcnt_q;
	logic                neg_q;
	logic                off_zero_q;

	// output registers
	logic signed [STEP_W-1:0] out_xs_q;
	logic signed [STEP_W-1:0] out_ys_q;
	logic [POS_W-1:0]    out_xp_q;
	logic [POS_W-1:0]    out_yp_q;
	logic                out_done_q;

	// effective levels, range and start sign
	logic [SL_W-1:0]     sl_sat;
	logic [SL_W-1:0]     rng_sat;
	logic [LVL_W-1:0]    lvl;
	logic [IDX_W-1:0]    lvl_i;
	logic [IDX_W-1:0]    two_l;
	logic [IDX_W-1:0]    lvl_plus_r;
	logic [IDX_W-1:0]    lvl_minus_r;
	logic signed [STEP_W-1:0] ysgn;

	always_comb begin
		if (speed_levels_q == '0) begin
			sl_sat = SL_W'(1);
		end else if (speed_levels_q > SL_W'(MAX_LEVELS)) begin
			sl_sat = SL_W'(MAX_LEVELS);
		end else begin
			sl_sat = speed_levels_q;
		end
		if (max_range_q == '0) begin
			rng_sat = SL_W'(1);
		end else if (max_range_q > sl_sat) begin
			rng_sat = sl_sat;
		end else begin
			rng_sat = max_range_q;
		end
	end

	assign lvl         = LVL_W'(sl_sat);
	assign lvl_i       = IDX_W'(lvl);
	assign two_l       = IDX_W'({lvl, 1'b0});
	assign lvl_plus_r  = lvl_i + IDX_W'(rng_sat);
	assign lvl_minus_r = lvl_i - IDX_W'(rng_sat);
	assign ysgn        = start_sign_q[1] ? 2'sb11 : {1'b0, start_sign_q[0]};

	// pressed flags from active-low buttons
	logic south, north, west, east, any_btn;
	assign south   = ~btn_q[3];
	assign north   = ~btn_q[2];
	assign west    = ~btn_q[1];
	assign east    = ~btn_q[0];
	assign any_btn = south | north | west | east;

	// indices saturated into the table, and the run decision
	logic [IDX_W-1:0] xi_c, yi_c;
	logic             run;
	assign xi_c = (x_ax_q.idx > two_l) ? two_l : x_ax_q.idx;
	assign yi_c = (y_ax_q.idx > two_l) ? two_l : y_ax_q.idx;
	assign run  = any_btn | (session_q & ((xi_c != lvl_i) | (yi_c != lvl_i)));

	// axis tick decision for the selected axis
	axis_t                    cur;
	logic                     plus, minus, at_c, quiet, skip_wait, ramp_wait;
	logic                     up, dn, inc, dec;
	logic signed [STEP_W-1:0] sgn, dlt, step_v;
	logic [IDX_W-1:0]         idx1, idx2;

	always_comb begin
		cur       = axis_q ? y_ax_q : x_ax_q;
		plus      = axis_q ? west : north;
		minus     = axis_q ? east : south;
		sgn       = axis_q ? ysgn : 2'sb01;
		at_c      = (cur.idx == lvl_i);
		quiet     = at_c & ~plus & ~minus;
		skip_wait = (cur.skip > CNT_W'(1));
		ramp_wait = (cur.ramp > CNT_W'(1));
		if (plus && !minus) begin
			dlt = sgn;
		end else if (minus && !plus) begin
			dlt = -sgn;
		end else begin
			dlt = 2'sb00;
		end
		idx1   = at_c ? (cur.idx + IDX_W'(dlt)) : cur.idx;
		up     = (idx1 > lvl_i);
		dn     = (idx1 < lvl_i);
		inc    = (plus & ~minus & (idx1 < lvl_plus_r)) | ((plus == minus) & (idx1 < lvl_i));
		dec    = (minus & ~plus & (idx1 > lvl_minus_r)) | ((plus == minus) & (idx1 > lvl_i));
		if (inc) begin
			idx2 = idx1 + IDX_W'(1);
		end else if (dec) begin
			idx2 = idx1 - IDX_W'(1);
		end else begin
			idx2 = idx1;
		end
		if (up) begin
			step_v = 2'sb01;
		end else if (dn) begin
			step_v = 2'sb11;
		end else begin
			step_v = 2'sb00;
		end
	end

	// product of the level offset, less one for a hold or two for a delay, and the register span
	logic [IDX_W-1:0]         off;
	logic signed [IDX_W:0]    term;
	logic signed [CFG_W:0]    diff;
	logic signed [PROD_W-1:0] prod;
	logic [PROD_W-1:0]        prod_mag;

	always_comb begin
		off  = (cur.idx > lvl_i) ? (cur.idx - lvl_i) : (lvl_i - cur.idx);
		term = (IDX_W+1)'({1'b0, off}) - (kind_q ? (IDX_W+1)'(2) : (IDX_W+1)'(1));
		diff = kind_q ? ({1'b0, max_delay_q} - {1'b0, min_delay_q})
		              : ({1'b0, max_steps_q} - {1'b0, min_steps_q});
		prod = PROD_W'(term) * PROD_W'(diff);
		prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
	end

	// two restoring divide steps per cycle by the level count
	logic [LVL_W:0]    trial;
	logic [LVL_W-1:0]  rem_v;
	logic [DIVN_W-1:0] num_v;
	logic              qbit;

	always_comb begin
		rem_v = rem_q;
		num_v = num_q;
		trial = '0;
		qbit  = 1'b0;
		for (int k = 0; k < 2; k++) begin
			trial = {rem_v, num_v[DIVN_W-1]};
			qbit  = (trial >= {1'b0, lvl});
			if (qbit) begin
				trial = trial - {1'b0, lvl};
			end
			rem_v = trial[LVL_W-1:0];
			num_v = {num_v[DIVN_W-2:0], qbit};
		end
	end

	// signed quotient and the saturated delay or hold value
	logic signed [DIVN_W:0]  quo;
	logic signed [RES_W-1:0] res;
	logic [CNT_W-1:0]        wb_val;

	always_comb begin
		quo = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
		res = kind_q ? (RES_W'({1'b0, max_delay_q}) - RES_W'(quo))
		             : (RES_W'({1'b0, min_steps_q}) + RES_W'(quo));
		if (off_zero_q) begin
			wb_val = kind_q ? CNT_W'(max_delay_q) : '0;
		end else if (res[RES_W-1]) begin
			wb_val = '0;
		end else begin
			wb_val = CNT_W'(res);
		end
	end

	// handshake outputs
	logic out_free;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_levels_q <= RST_SPEED_LEVELS;
			max_range_q    <= RST_MAX_RANGE;
			min_steps_q    <= RST_MIN_STEPS;
			max_steps_q    <= RST_MAX_STEPS;
			min_delay_q    <= RST_MIN_DELAY;
			max_delay_q    <= RST_MAX_DELAY;
			start_sign_q   <= RST_START_SIGN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SPEED_LEVELS: speed_levels_q <= cfg_data[SL_W-1:0];
				REG_MAX_RANGE:    max_range_q    <= cfg_data[SL_W-1:0];
				REG_MIN_STEPS:    min_steps_q    <= cfg_data;
				REG_MAX_STEPS:    max_steps_q    <= cfg_data;
				REG_MIN_DELAY:    min_delay_q    <= cfg_data;
				REG_MAX_DELAY:    max_delay_q    <= cfg_data;
				REG_START_SIGN:   start_sign_q   <= cfg_data[SIGN_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			kind_q      <= 1'b0;
			session_q   <= 1'b0;
			done_q      <= 1'b0;
			x_ax_q      <= '{idx: IDX_W'(RST_SPEED_LEVELS), skip: '0, ramp: '0};
			y_ax_q      <= '{idx: IDX_W'(RST_SPEED_LEVELS), skip: '0, ramp: '0};
			x_pos_q     <= '0;
			y_pos_q     <= '0;
			x_step_q    <= '0;
			y_step_q    <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: load on finish, drop after its transfer
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
					end
				end
				// saturate indices, start or end a session
				S_START: begin
					x_step_q <= '0;
					y_step_q <= '0;
					axis_q   <= 1'b0;
					done_q   <= ~run & session_q;
					if (run) begin
						if (!session_q) begin
							x_ax_q    <= '{idx: lvl_i, skip: '0, ramp: '0};
							y_ax_q    <= '{idx: lvl_i, skip: '0, ramp: '0};
							session_q <= 1'b1;
						end else begin
							x_ax_q.idx <= xi_c;
							y_ax_q.idx <= yi_c;
						end
						state_q <= S_EVAL;
					end else begin
						x_ax_q.idx <= xi_c;
						y_ax_q.idx <= yi_c;
						session_q  <= 1'b0;
						state_q    <= S_FINISH;
					end
				end
				// one axis tick decision
				S_EVAL: begin
					if (quiet) begin
						axis_q  <= 1'b1;
						state_q <= axis_q ? S_FINISH : S_EVAL;
					end else if (skip_wait) begin
						if (axis_q) begin
							y_ax_q.skip <= cur.skip - CNT_W'(1);
						end else begin
							x_ax_q.skip <= cur.skip - CNT_W'(1);
						end
						axis_q  <= 1'b1;
						state_q <= axis_q ? S_FINISH : S_EVAL;
					end else begin
						if (axis_q) begin
							y_step_q <= step_v;
							y_pos_q  <= y_pos_q + POS_W'(step_v);
						end else begin
							x_step_q <= step_v;
							x_pos_q  <= x_pos_q + POS_W'(step_v);
						end
						if ((up || dn) && !ramp_wait) begin
							// ramp expired: move the index and reload the hold
							if (axis_q) begin
								y_ax_q.idx <= idx2;
							end else begin
								x_ax_q.idx <= idx2;
							end
							kind_q <= 1'b0;
						end else begin
							if (axis_q) begin
								y_ax_q.idx <= idx1;
								if (up || dn) begin
									y_ax_q.ramp <= cur.ramp - CNT_W'(1);
								end
							end else begin
								x_ax_q.idx <= idx1;
								if (up || dn) begin
									x_ax_q.ramp <= cur.ramp - CNT_W'(1);
								end
							end
							kind_q <= 1'b1;
						end
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(DIV_CYC - 1)) begin
						state_q <= S_WB;
					end
				end
				// store hold or delay, then go on
				S_WB: begin
					if (!kind_q) begin
						if (axis_q) begin
							y_ax_q.ramp <= wb_val;
						end else begin
							x_ax_q.ramp <= wb_val;
						end
						kind_q  <= 1'b1;
						state_q <= S_MUL;
					end else begin
						if (axis_q) begin
							y_ax_q.skip <= wb_val;
						end else begin
							x_ax_q.skip <= wb_val;
						end
						axis_q  <= 1'b1;
						state_q <= axis_q ? S_FINISH : S_EVAL;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			btn_q <= buttons;
		end
		if (state_q == S_MUL) begin
			num_q      <= DIVN_W'(prod_mag);
			neg_q      <= prod[PROD_W-1];
			rem_q      <= '0;
			off_zero_q <= (off == '0);
		end else if (state_q == S_DIV) begin
			num_q <= num_v;
			rem_q <= rem_v;
		end
		if (state_q == S_FINISH && out_free) begin
			out_xs_q   <= x_step_q;
			out_ys_q   <= y_step_q;
			out_xp_q   <= x_pos_q;
			out_yp_q   <= y_pos_q;
			out_done_q <= done_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign x_step       = out_xs_q;
	assign y_step       = out_ys_q;
	assign x_position   = out_xp_q;
	assign y_position   = out_yp_q;
	assign session_done = out_done_q;

	// checks
	`PSR_ASSERT_NEXT(a_transfer_starts, in_valid && !in_stall, state_q == S_START)
	`PSR_ASSERT_SAME(a_done_has_no_steps, out_valid_q && out_done_q, out_xs_q == '0 && out_ys_q == '0)
	`PSR_ASSERT_SAME(a_idx_in_table, state_q == S_MUL, cur.idx <= two_l)
	`PSR_ASSERT_NEXT(a_div_ends_in_wb, state_q == S_DIV && dcnt_q == DCNT_W'(DIV_CYC - 1), state_q == S_WB)
	`PSR_ASSERT_NEXT(a_session_end, state_q == S_START && !run && session_q, !session_q && done_q)

endmodule

### dv/paddle_stepper_ramp_top_test.sv
// self-checking testbench for the paddle stepper ramp block
`timescale 1ns / 1ps

module paddle_stepper_ramp_top_test;
	import psr_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_LEN    = 400;
	localparam int PRINT_LIMIT = 20;

	// one expected tick outcome
	typedef struct {
		logic signed [STEP_W-1:0] x_step;
		logic signed [STEP_W-1:0] y_step;
		logic signed [POS_W-1:0]  x_pos;
		logic signed [POS_W-1:0]  y_pos;
		logic                     done;
	} tick_result_t;

	// tracked state of one axis
	typedef struct {
		int idx;
		int skip;
		int ramp;
	} axis_track_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [BTN_W-1:0]   buttons = '1;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [STEP_W-1:0] x_step;
	logic signed [STEP_W-1:0] y_step;
	logic signed [POS_W-1:0]  x_position;
	logic signed [POS_W-1:0]  y_position;
	logic               session_done;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	// register copies used for prediction
	logic [SL_W-1:0]   cfg_levels;
	logic [SL_W-1:0]   cfg_range;
	logic [CFG_W-1:0]  cfg_min_steps;
	logic [CFG_W-1:0]  cfg_max_steps;
	logic [CFG_W-1:0]  cfg_min_delay;
	logic [CFG_W-1:0]  cfg_max_delay;
	logic [SIGN_W-1:0] cfg_sign;

	// predicted block state
	axis_track_t x_axis, y_axis;
	logic [POS_W-1:0] x_pos_track, y_pos_track;
	bit session_on;

	logic [BTN_W-1:0] pending_buttons[$];
	tick_result_t     expected_ticks[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int queued_count = 0;
	int checked_count = 0;
	int error_count = 0;
	int cycle_count = 0;
	int session_count = 0;
	int x_step_count = 0;
	int y_step_count = 0;
	int setting_count = 0;

	paddle_stepper_ramp_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.buttons     (buttons),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.x_step      (x_step),
		.y_step      (y_step),
		.x_position  (x_position),
		.y_position  (y_position),
		.session_done(session_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// mismatch reporting
	task automatic flag_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// speed levels after saturation into 1..MAX_LEVELS
	function automatic int levels_used();
		int l;
		l = int'(cfg_levels);
		if (l < 1) l = 1;
		if (l > MAX_LEVELS) l = MAX_LEVELS;
		return l;
	endfunction

	function automatic int range_used(input int l);
		int r;
		r = int'(cfg_range);
		if (r < 1) r = 1;
		if (r > l) r = l;
		return r;
	endfunction

	// start sign: pattern -2 behaves as -1
	function automatic int start_sign_used();
		if (cfg_sign == 2'b00) return 0;
		if (cfg_sign == 2'b01) return 1;
		return -1;
	endfunction

	function automatic int offset_of(input int idx, input int l);
		return (idx > l) ? idx - l : l - idx;
	endfunction

	// ramp hold count for a level
	function automatic int hold_for(input int idx, input int l);
		int off;
		longint v;
		off = offset_of(idx, l);
		if (off == 0) return 0;
		v = longint'(cfg_min_steps) + (longint'(off - 1) *
			(longint'(cfg_max_steps) - longint'(cfg_min_steps))) / l;
		return (v < 0) ? 0 : int'(v);
	endfunction

	// tick delay for a level, negative values clipped to zero
	function automatic int delay_for(input int idx, input int l);
		int off;
		longint v;
		off = offset_of(idx, l);
		if (off == 0) return int'(cfg_max_delay);
		v = longint'(cfg_max_delay) - (longint'(off - 2) *
			(longint'(cfg_max_delay) - longint'(cfg_min_delay))) / l;
		return (v < 0) ? 0 : int'(v);
	endfunction

	function automatic void home_axis(inout axis_track_t a, input int l);
		a.idx = l;
		a.skip = 0;
		a.ramp = 0;
	endfunction

	// one axis for one running tick, returns the step direction
	function automatic int advance_axis(inout axis_track_t a, input bit plus,
			input bit minus, input int start, input int l, input int r);
		int dir;
		dir = 0;
		if (a.idx == l && !plus && !minus) return 0;
		if (a.skip > 1) begin
			a.skip--;
			return 0;
		end
		if (a.idx == l && (plus || minus))
			a.idx += (plus ? start : 0) - (minus ? start : 0);
		if (a.idx > l) dir = 1;
		else if (a.idx < l) dir = -1;
		if (dir != 0) begin
			if (a.ramp > 1) begin
				a.ramp--;
			end else begin
				if ((plus && !minus && a.idx < l + r) || (plus == minus && a.idx < l))
					a.idx++;
				else if ((minus && !plus && a.idx > l - r) || (plus == minus && a.idx > l))
					a.idx--;
				a.ramp = hold_for(a.idx, l);
			end
		end
		a.skip = delay_for(a.idx, l);
		return dir;
	endfunction

	function automatic void reset_tracker();
		cfg_levels = RST_SPEED_LEVELS;
		cfg_range = RST_MAX_RANGE;
		cfg_min_steps = RST_MIN_STEPS;
		cfg_max_steps = RST_MAX_STEPS;
		cfg_min_delay = RST_MIN_DELAY;
		cfg_max_delay = RST_MAX_DELAY;
		cfg_sign = RST_START_SIGN;
		home_axis(x_axis, levels_used());
		home_axis(y_axis, levels_used());
		x_pos_track = '0;
		y_pos_track = '0;
		session_on = 1'b0;
	endfunction

	function automatic void track_reg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		case (idx)
			REG_SPEED_LEVELS: cfg_levels = data[SL_W-1:0];
			REG_MAX_RANGE:    cfg_range = data[SL_W-1:0];
			REG_MIN_STEPS:    cfg_min_steps = data;
			REG_MAX_STEPS:    cfg_max_steps = data;
			REG_MIN_DELAY:    cfg_min_delay = data;
			REG_MAX_DELAY:    cfg_max_delay = data;
			REG_START_SIGN:   cfg_sign = data[SIGN_W-1:0];
			default: ;
		endcase
	endfunction

	// expected outcome of one accepted tick
	function automatic void predict_tick(input logic [BTN_W-1:0] b);
		bit south, north, west, east, run;
		int l, r, xs, ys;
		tick_result_t res;
		south = !b[3];
		north = !b[2];
		west = !b[1];
		east = !b[0];
		l = levels_used();
		r = range_used(l);
		xs = 0;
		ys = 0;
		res.done = 1'b0;
		// leftover index from a larger level count
		if (x_axis.idx < 0) x_axis.idx = 0;
		if (x_axis.idx > 2 * l) x_axis.idx = 2 * l;
		if (y_axis.idx < 0) y_axis.idx = 0;
		if (y_axis.idx > 2 * l) y_axis.idx = 2 * l;
		run = south || north || west || east ||
			(session_on && (x_axis.idx != l || y_axis.idx != l));
		if (run) begin
			if (!session_on) begin
				home_axis(x_axis, l);
				home_axis(y_axis, l);
				session_on = 1'b1;
			end
			xs = advance_axis(x_axis, north, south, 1, l, r);
			ys = advance_axis(y_axis, west, east, start_sign_used(), l, r);
			x_pos_track = x_pos_track + POS_W'(xs);
			y_pos_track = y_pos_track + POS_W'(ys);
		end else if (session_on) begin
			session_on = 1'b0;
			res.done = 1'b1;
		end
		res.x_step = STEP_W'(xs);
		res.y_step = STEP_W'(ys);
		res.x_pos = x_pos_track;
		res.y_pos = y_pos_track;
		expected_ticks.push_back(res);
	endfunction

	// tick driver: holds the payload until the transfer completes
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predict_tick(buttons);
			if (!in_valid || !in_stall) begin
				if (pending_buttons.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					buttons <= pending_buttons.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, timed in its own process
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver stall
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			checked_count++;
			if (expected_ticks.size() == 0) begin
				flag_mismatch($sformatf("result %0d arrived with nothing expected", checked_count));
			end else begin
				want = expected_ticks.pop_front();
				if (want.done) session_count++;
				if (want.x_step != 0) x_step_count++;
				if (want.y_step != 0) y_step_count++;
				if (x_step !== want.x_step)
					flag_mismatch($sformatf("result %0d x_step %0d, want %0d",
						checked_count, x_step, want.x_step));
				if (y_step !== want.y_step)
					flag_mismatch($sformatf("result %0d y_step %0d, want %0d",
						checked_count, y_step, want.y_step));
				if (x_position !== want.x_pos)
					flag_mismatch($sformatf("result %0d x_position %0d, want %0d",
						checked_count, x_position, want.x_pos));
				if (y_position !== want.y_pos)
					flag_mismatch($sformatf("result %0d y_position %0d, want %0d",
						checked_count, y_position, want.y_pos));
				if (session_done !== want.done)
					flag_mismatch($sformatf("result %0d session_done %0b, want %0b",
						checked_count, session_done, want.done));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_ticks(input logic [BTN_W-1:0] b, input int n);
		repeat (n) begin
			pending_buttons.push_back(b);
			queued_count++;
		end
	endtask

	// wait until every queued tick has come back
	task automatic wait_drained();
		while (checked_count < queued_count)
			@(posedge clk);
		@(posedge clk);
	endtask

	// register write transfer, valid stays high across back-to-back writes
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		track_reg_write(idx, data);
	endtask

	task automatic set_config(input int levels, input int range_lim, input int min_st,
			input int max_st, input int min_dl, input int max_dl, input int sign_bits);
		write_reg(REG_SPEED_LEVELS, CFG_W'(levels));
		write_reg(REG_MAX_RANGE, CFG_W'(range_lim));
		write_reg(REG_MIN_STEPS, CFG_W'(min_st));
		write_reg(REG_MAX_STEPS, CFG_W'(max_st));
		write_reg(REG_MIN_DELAY, CFG_W'(min_dl));
		write_reg(REG_MAX_DELAY, CFG_W'(max_dl));
		write_reg(REG_START_SIGN, CFG_W'(sign_bits));
		cfg_valid <= 1'b0;
		setting_count++;
	endtask

	// press-and-release runs with random content, plus some noise
	task automatic queue_random(input int n);
		int start_count, kind, len;
		logic [BTN_W-1:0] press;
		start_count = queued_count;
		while (queued_count - start_count < n) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				case ($urandom_range(0, 3))
					0: press = BTN_W'(1 << $urandom_range(0, 3));
					1: press = BTN_W'((1 << $urandom_range(0, 1)) | (4 << $urandom_range(0, 1)));
					2: press = BTN_W'($urandom_range(1, 15));
					default: press = $urandom_range(0, 1) ? 4'b1100 : 4'b0011;
				endcase
				queue_ticks(~press, $urandom_range(2, 40));
				// direction change while still moving
				if ($urandom_range(0, 2) == 0)
					queue_ticks(~BTN_W'(1 << $urandom_range(0, 3)), $urandom_range(2, 30));
				queue_ticks('1, $urandom_range(0, 50));
			end else begin
				len = $urandom_range(1, 8);
				repeat (len) queue_ticks(BTN_W'($urandom_range(0, 15)), 1);
			end
		end
	endtask

	// stimulus sequence
	initial begin
		reset_tracker();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 28;
		recv_stall_pct = 75;

		// default registers: idle tick, all pressed, east only, session end
		queue_ticks(4'hF, 1);
		queue_ticks(4'h0, 1);
		queue_ticks(4'hE, 1);
		queue_ticks(4'hF, 1);
		wait_drained();

		// one level, zero range, start sign pattern -2, negative delay
		set_config(1, 0, 0, 65535, 65535, 0, 2);
		queue_ticks(4'hD, 3);
		queue_ticks(4'hE, 2);
		queue_ticks(4'h7, 1);
		queue_ticks(4'hB, 1);
		queue_ticks(4'h0, 1);
		queue_ticks(4'hF, 4);
		wait_drained();

		// drive x far out, then shrink the level count mid-session
		set_config(16, 16, 0, 0, 0, 0, 1);
		queue_ticks(4'hB, 4);
		wait_drained();
		write_reg(REG_SPEED_LEVELS, CFG_W'(2));
		cfg_valid <= 1'b0;
		queue_ticks(4'hF, 5);
		wait_drained();

		// random part, sender mostly busy and receiver mostly stalling
		set_config(16, 16, 0, 3, 0, 2, 1);
		queue_random(300);
		hold_req <= hold_req + 1;
		wait_drained();
		set_config(3, 2, 1, 2, 1, 4, 3);
		queue_random(250);
		wait_drained();

		// sender mostly idle, receiver mostly ready
		send_idle_pct = 75;
		recv_stall_pct = 28;
		set_config(31, 0, 65535, 0, 0, 65535, 0);
		queue_random(150);
		wait_drained();
		set_config($urandom_range(1, 8), $urandom_range(0, 31), $urandom_range(0, 4),
			$urandom_range(0, 4), $urandom_range(0, 5), $urandom_range(0, 5),
			$urandom_range(0, 3));
		queue_random(300);
		wait_drained();

		// no idling on either side
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(0, 31, $urandom_range(0, 3), $urandom_range(0, 8), 5, 0, 1);
		queue_random(250);
		wait_drained();
		set_config($urandom_range(2, 16), $urandom_range(1, 16), $urandom_range(0, 3),
			$urandom_range(0, 6), $urandom_range(0, 2), $urandom_range(0, 6),
			$urandom_range(0, 3));
		queue_random(250);
		wait_drained();

		// let any stray result show up
		repeat (60) @(posedge clk);
		if (expected_ticks.size() != 0)
			flag_mismatch($sformatf("%0d expected results never arrived", expected_ticks.size()));

		$display("checked %0d ticks over %0d register settings, %0d sessions closed",
			checked_count, setting_count, session_count);
		$display("%0d x steps and %0d y steps, one receiver hold-off of %0d cycles",
			x_step_count, y_step_count, HOLD_LEN);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
